@@ rtl/ltp_pkg.sv @@
// shared types, constants and helpers for the twinkle pixel engine
`default_nettype none

package ltp_pkg;

    // pixel memory geometry
    localparam int NUM_PIXELS = 256;
    localparam int ADDR_W     = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_SEED   = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RATE_STEP   = 2'd0;
    localparam logic [1:0] CFG_BRIGHT_STEP = 2'd1;
    localparam logic [1:0] CFG_SPAWN_SCALE = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] RATE_STEP_RST   = 8'd4;
    localparam logic [7:0] BRIGHT_STEP_RST = 8'd6;
    localparam logic [7:0] SPAWN_SCALE_RST = 8'd0;

    // spawn modulus and full brightness
    localparam logic [7:0] SPAWN_MOD  = 8'd11;
    localparam logic [7:0] LEVEL_FULL = 8'd255;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] pixel_index;
        logic [7:0] rand_spawn;
        logic [7:0] rand_color;
        logic [7:0] rand_rate;
        logic [7:0] rand_level;
    } t_item;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       lit;
        logic [7:0] palette_index;
        logic [7:0] brightness;
    } t_result;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] rate;
        logic [7:0] level;
    } t_pixel;

    typedef struct packed {
        logic [7:0] rate_step;
        logic [7:0] bright_step;
        logic [3:0] spawn_lim;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic give;
    } t_tok_op;

    // v mod 11 through a reciprocal multiply, exact for all 8-bit v
    function automatic logic [3:0] mod11(input logic [7:0] v);
        logic [16:0] prod;
        logic [4:0]  q;
        logic [7:0]  back;
        logic [7:0]  rem;
        prod = {9'b0, v} * 17'd373;
        q    = prod[16:12];
        back = {3'b0, q} * SPAWN_MOD;
        rem  = v - back;
        return rem[3:0];
    endfunction

    function automatic logic pixel_in_range(input logic [7:0] idx);
        return (32'(idx) < NUM_PIXELS);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ltp_pixel_mem.sv @@
// pixel store: one write port, one registered read port
`default_nettype none

module ltp_pixel_mem (
    input  wire                       i_clk,
    input  wire                       i_rd_en,
    input  wire [ltp_pkg::ADDR_W-1:0] i_rd_addr,
    output ltp_pkg::t_pixel           o_rd_data,
    input  wire                       i_wr_en,
    input  wire [ltp_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire ltp_pkg::t_pixel      i_wr_data
);

    ltp_pkg::t_pixel r_mem [ltp_pkg::NUM_PIXELS];
    ltp_pkg::t_pixel r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/ltp_pixel_update.sv @@
// next pixel state and token traffic for one seed or update word
`default_nettype none

module ltp_pixel_update (
    input  wire ltp_pkg::t_item   i_item,
    input  wire ltp_pkg::t_pixel  i_pix,
    input  wire ltp_pkg::t_cfg    i_cfg,
    input  wire                   i_tokens_avail,
    output ltp_pkg::t_pixel       o_pix,
    output ltp_pkg::t_tok_op      o_tok
);

    logic [11:0] spawn_prod;
    logic        spawn_pass;
    logic [7:0]  seed_span;
    logic [15:0] seed_prod;
    logic [15:0] idle_prod;
    logic [7:0]  seed_rate;
    logic [7:0]  idle_rate;
    logic        rising;
    logic [9:0]  rise_sum;
    logic [9:0]  fall_drop;

    // spawn test: rand * lim must stay below 256
    assign spawn_prod = {4'b0, i_item.rand_spawn} * {8'b0, i_cfg.spawn_lim};
    assign spawn_pass = (spawn_prod[11:8] == 4'd0);

    assign seed_span = {i_cfg.rate_step[6:0], 1'b0};
    assign seed_prod = {8'b0, i_item.rand_rate} * {8'b0, seed_span};
    assign idle_prod = {8'b0, i_item.rand_rate} * {8'b0, i_cfg.rate_step};
    assign seed_rate = seed_prod[15:8] + 8'd1;
    assign idle_rate = idle_prod[15:8] + 8'd1;

    assign rising    = (i_pix.rate <= i_cfg.rate_step);
    assign rise_sum  = {2'b0, i_pix.level} + {2'b0, i_pix.rate} + {2'b0, i_cfg.bright_step};
    // rate is above rate_step when falling, so this stays positive
    assign fall_drop = {2'b0, i_pix.rate} - {2'b0, i_cfg.rate_step}
                     + {2'b0, i_cfg.bright_step};

    always_comb begin
        o_pix      = i_pix;
        o_tok.take = 1'b0;
        o_tok.give = 1'b0;
        case (i_item.cmd)
            ltp_pkg::CMD_SEED: begin
                if (spawn_pass) begin
                    o_pix.color = i_item.rand_color;
                    o_pix.rate  = seed_rate;
                    o_pix.level = i_item.rand_level;
                end else begin
                    o_pix = '0;
                end
            end
            ltp_pkg::CMD_UPDATE: begin
                if (i_pix.level == 8'd0) begin
                    if (spawn_pass && i_tokens_avail) begin
                        o_pix.color = i_item.rand_color;
                        o_pix.rate  = idle_rate;
                        o_pix.level = idle_rate;
                        o_tok.take  = 1'b1;
                    end
                end else if (rising) begin
                    if (rise_sum > {2'b0, ltp_pkg::LEVEL_FULL}) begin
                        o_pix.level = ltp_pkg::LEVEL_FULL;
                        o_pix.rate  = i_pix.rate + i_cfg.rate_step;
                    end else begin
                        o_pix.level = rise_sum[7:0];
                    end
                end else begin
                    if ({2'b0, i_pix.level} <= fall_drop) begin
                        o_pix.level = 8'd0;
                        o_tok.give  = 1'b1;
                    end else begin
                        o_pix.level = i_pix.level - fall_drop[7:0];
                    end
                end
            end
            default: begin
                o_pix = i_pix;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/led_twinkle_pixel_engine.sv @@
// top level of the twinkle pixel engine: word intake, pixel pipeline, tokens, config
// path: an update word passes the stage 1 register, then the result register behind o_done
// throughput: one word per cycle, busy never rises; set by the single pixel memory port
//   pair, with a one-entry write bypass covering back-to-back words on one pixel
// the receiver cannot stall: each result shows for exactly one cycle on o_done
// reset (synchronous, active low) clears the pipeline valids and token count and loads the
//   config reset values; the pixel memory is not cleared and must be seeded before update
`default_nettype none

module led_twinkle_pixel_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // command word intake
    input  wire                   start,
    output logic                  busy,
    input  wire ltp_pkg::t_item   i_item,
    // result words
    output logic                  o_done,
    output ltp_pkg::t_result      o_result,
    // config write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [1:0]             i_cfg_index,
    input  wire [7:0]             i_cfg_data
);

    localparam int AW = ltp_pkg::ADDR_W;

    // config registers; the spawn limit keeps spawn_scale mod 11 ready to use
    logic [7:0] r_rate_step;
    logic [7:0] r_bright_step;
    logic [3:0] r_spawn_lim;
    logic       cfg_wr;

    // stage 1: the word held while its pixel comes out of memory
    logic            r_s1_valid;
    ltp_pkg::t_item  r_s1_item;
    logic            accept;

    // bypass for the write made at the edge the stage 1 word was read
    logic            r_fwd_valid;
    logic [AW-1:0]   r_fwd_addr;
    ltp_pkg::t_pixel r_fwd_data;

    // token counter
    logic [7:0]      r_tokens;
    logic [7:0]      n_tokens;

    // result register
    logic            r_res_valid;
    ltp_pkg::t_result r_result;

    // stage 1 working signals
    logic             s1_in_range;
    logic [AW-1:0]    s1_addr;
    logic             s1_write;
    logic             s1_update;
    ltp_pkg::t_pixel  mem_rd_data;
    ltp_pkg::t_pixel  pix_cur;
    ltp_pkg::t_pixel  pix_next;
    ltp_pkg::t_cfg    cfg;
    ltp_pkg::t_tok_op tok_op;

    // every word can be taken every cycle
    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step   <= ltp_pkg::RATE_STEP_RST;
            r_bright_step <= ltp_pkg::BRIGHT_STEP_RST;
            r_spawn_lim   <= ltp_pkg::mod11(ltp_pkg::SPAWN_SCALE_RST);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                ltp_pkg::CFG_RATE_STEP:   r_rate_step   <= i_cfg_data;
                ltp_pkg::CFG_BRIGHT_STEP: r_bright_step <= i_cfg_data;
                ltp_pkg::CFG_SPAWN_SCALE: r_spawn_lim   <= ltp_pkg::mod11(i_cfg_data);
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign cfg.rate_step   = r_rate_step;
    assign cfg.bright_step = r_bright_step;
    assign cfg.spawn_lim   = r_spawn_lim;

    // intake register, memory read issued at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
        end
    end

    ltp_pixel_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_item.pixel_index)),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (s1_write),
        .i_wr_addr (s1_addr),
        .i_wr_data (pix_next)
    );

    assign s1_in_range = ltp_pkg::pixel_in_range(r_s1_item.pixel_index);
    assign s1_addr     = AW'(r_s1_item.pixel_index);
    assign s1_write    = r_s1_valid && s1_in_range
                      && (r_s1_item.cmd == ltp_pkg::CMD_SEED
                          || r_s1_item.cmd == ltp_pkg::CMD_UPDATE);
    assign s1_update   = r_s1_valid && s1_in_range && (r_s1_item.cmd == ltp_pkg::CMD_UPDATE);

    // memory read returns old data when the previous word wrote the same pixel
    assign pix_cur = (r_fwd_valid && (r_fwd_addr == s1_addr)) ? r_fwd_data : mem_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= s1_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= s1_addr;
        r_fwd_data <= pix_next;
    end

    ltp_pixel_update u_update (
        .i_item         (r_s1_item),
        .i_pix          (pix_cur),
        .i_cfg          (cfg),
        .i_tokens_avail (r_tokens != 8'd0),
        .o_pix          (pix_next),
        .o_tok          (tok_op)
    );

    // token count: clear word, spawn takes one, a pixel going dark gives one back
    always_comb begin
        n_tokens = r_tokens;
        if (r_s1_valid && r_s1_item.cmd == ltp_pkg::CMD_CLEAR) begin
            n_tokens = 8'd0;
        end else if (s1_update && tok_op.take) begin
            n_tokens = r_tokens - 8'd1;
        end else if (s1_update && tok_op.give) begin
            n_tokens = r_tokens + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tokens <= 8'd0;
        end else begin
            r_tokens <= n_tokens;
        end
    end

    // result register, one strobe per in-range update word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= s1_update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_update) begin
            r_result.out_pixel     <= r_s1_item.pixel_index;
            r_result.lit           <= (pix_next.level != 8'd0);
            r_result.palette_index <= (pix_next.level != 8'd0) ? pix_next.color : 8'd0;
            r_result.brightness    <= pix_next.level;
        end
    end

    assign o_done   = r_res_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
